// ----- sv/slpg_pkg.sv -----
// shared constants, types and helpers of the sphere lattice point generator
// no dependencies
package slpg_pkg;

  localparam int MaxDim   = 8;
  localparam int PartBits = 8;
  localparam int DenW     = 8;
  localparam int DimW     = 4;
  localparam int CoordW   = 16;
  localparam int MagW     = 15;
  localparam int FracBits = 14;
  localparam int QuotW    = PartBits + 2 * FracBits + 2;
  localparam int RootW    = QuotW / 2;
  localparam int RemW     = RootW + 1;
  localparam int CntW     = $clog2(QuotW);
  localparam int IdxW     = $clog2(MaxDim);
  localparam int NzW      = $clog2(MaxDim + 1);
  localparam int AddrW    = 3;
  localparam int ApbW     = 32;

  typedef enum logic [0:0] {
    RegDen = 1'b0,
    RegDim = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [DenW-1:0] den;
    logic [DimW-1:0] dim;
    logic            wr;
  } cfg_t;

  // zero denominator acts as one
  function automatic logic [PartBits-1:0] eff_den(input logic [DenW-1:0] d);
    logic [PartBits-1:0] r;
    r = PartBits'(d);
    if (d == '0) r = PartBits'(1);
    return r;
  endfunction

  // dimension clamped to 2..MaxDim
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    r = d;
    if (d < DimW'(2)) r = DimW'(2);
    if (d > DimW'(MaxDim)) r = DimW'(MaxDim);
    return r;
  endfunction

endpackage

// ----- sv/slpg_apb.sv -----
// configuration registers behind the apb-style port
// depends on slpg_pkg
module slpg_apb (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [slpg_pkg::AddrW-1:0] paddr,
  input  logic [slpg_pkg::ApbW-1:0]  pwdata,
  output logic [slpg_pkg::ApbW-1:0]  prdata,
  output logic                      pready,
  output slpg_pkg::cfg_t            cfg_o
);

  logic [slpg_pkg::DenW-1:0] den_q;
  logic [slpg_pkg::DimW-1:0] dim_q;
  logic                      wr;
  slpg_pkg::reg_idx_e        sel;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign sel    = slpg_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      den_q <= slpg_pkg::DenW'(4);
      dim_q <= slpg_pkg::DimW'(3);
    end else if (wr) begin
      unique case (sel)
        slpg_pkg::RegDen: den_q <= pwdata[slpg_pkg::DenW-1:0];
        slpg_pkg::RegDim: dim_q <= pwdata[slpg_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      slpg_pkg::RegDen: prdata = slpg_pkg::ApbW'(den_q);
      slpg_pkg::RegDim: prdata = slpg_pkg::ApbW'(dim_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.den = den_q;
  assign cfg_o.dim = dim_q;
  assign cfg_o.wr  = wr;

endmodule

// ----- sv/slpg_root.sv -----
// bit-serial magnitude unit: restoring divide then restoring square root
// depends on slpg_pkg
module slpg_root (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [slpg_pkg::PartBits-1:0] part_i,
  input  logic [slpg_pkg::PartBits-1:0] den_i,
  output logic                          done_o,
  output logic [slpg_pkg::MagW-1:0]     mag_o
);

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_e;

  rstate_e                        st_q;
  logic [slpg_pkg::CntW-1:0]      cnt_q;
  logic [slpg_pkg::QuotW-1:0]     q_q;
  logic [slpg_pkg::PartBits-1:0]  drem_q;
  logic [slpg_pkg::RemW-1:0]      srem_q;
  logic [slpg_pkg::RootW-1:0]     root_q;
  logic                           done_q;

  logic [slpg_pkg::PartBits:0]    dsh, dden;
  logic                           dge;
  logic [slpg_pkg::RemW+1:0]      ssh, strial;
  logic                           sge;
  logic [slpg_pkg::RootW:0]       rnd;

  assign dsh    = {drem_q, q_q[slpg_pkg::QuotW-1]};
  assign dden   = {1'b0, den_i};
  assign dge    = dsh >= dden;
  assign ssh    = {srem_q, q_q[slpg_pkg::QuotW-1 -: 2]};
  assign strial = {1'b0, root_q, 2'b01};
  assign sge    = ssh >= strial;
  // round to nearest: floor(sqrt) odd means round up
  assign rnd    = {1'b0, root_q} + (slpg_pkg::RootW+1)'(1);
  assign mag_o  = rnd[slpg_pkg::MagW:1];
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= R_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      // one-cycle pulse on the last root step
      done_q <= (st_q == R_SQRT) && (cnt_q == '0);
      unique case (st_q)
        R_IDLE: begin
          if (start_i) begin
            q_q    <= {part_i, (slpg_pkg::QuotW-slpg_pkg::PartBits)'(0)};
            drem_q <= '0;
            cnt_q  <= slpg_pkg::CntW'(slpg_pkg::QuotW - 1);
            st_q   <= R_DIV;
          end
        end
        R_DIV: begin
          drem_q <= dge ? slpg_pkg::PartBits'(dsh - dden) : dsh[slpg_pkg::PartBits-1:0];
          q_q    <= {q_q[slpg_pkg::QuotW-2:0], dge};
          if (cnt_q == '0) begin
            cnt_q  <= slpg_pkg::CntW'(slpg_pkg::RootW - 1);
            srem_q <= '0;
            root_q <= '0;
            st_q   <= R_SQRT;
          end else begin
            cnt_q <= cnt_q - slpg_pkg::CntW'(1);
          end
        end
        R_SQRT: begin
          srem_q <= sge ? slpg_pkg::RemW'(ssh - strial) : ssh[slpg_pkg::RemW-1:0];
          root_q <= {root_q[slpg_pkg::RootW-2:0], sge};
          q_q    <= {q_q[slpg_pkg::QuotW-3:0], 2'b00};
          if (cnt_q == '0) begin
            st_q <= R_IDLE;
          end else begin
            cnt_q <= cnt_q - slpg_pkg::CntW'(1);
          end
        end
        default: st_q <= R_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/sphere_lattice_point_generator_unit.sv -----
// top level of the sphere lattice point generator
// depends on slpg_pkg, slpg_apb and slpg_root
//
// Each input word (restart in bit 0 of s_axis_tdata_i) yields one output word with the
// next lattice point on the unit sphere: eight signed 16-bit coordinates, 16384 = 1.0,
// and tlast on the final point. A word that only steps the sign pattern goes straight to
// emit. A word that moves to a new composition (also restart, the first word after reset
// or after a register write) recomputes the magnitudes of all n coordinates in one shared
// bit-serial unit, a restoring divide then a restoring square root per coordinate. A
// finished word sits in the output register while the next input word is taken.
module sphere_lattice_point_generator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // restart in bit 0
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [7:0]                 s_axis_tdata_i,
  // coord_0 in bits 15:0 up to coord_7 in bits 127:112
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [127:0]               m_axis_tdata_o,
  output logic                       m_axis_tlast_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [slpg_pkg::AddrW-1:0] paddr,
  input  logic [slpg_pkg::ApbW-1:0]  pwdata,
  output logic [slpg_pkg::ApbW-1:0]  prdata,
  output logic                       pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT, ST_EMIT} state_e;

  localparam int MD = slpg_pkg::MaxDim;
  localparam int PB = slpg_pkg::PartBits;

  slpg_pkg::cfg_t cfg;

  state_e                         st_q;
  logic [PB-1:0]                  parts_q [MD];
  logic [slpg_pkg::MagW-1:0]      mag_q   [MD];
  logic [MD-1:0]                  sign_q;
  logic                           first_q;
  logic [slpg_pkg::IdxW-1:0]      idx_q;
  logic                           mv_q;
  logic [127:0]                   mdata_q;
  logic                           mlast_q;

  logic [PB-1:0]                  den_e;
  logic [slpg_pkg::DimW-1:0]      dim_e;
  logic [slpg_pkg::IdxW-1:0]      last_idx;
  logic [MD-1:0]                  nz;
  logic [slpg_pkg::NzW-1:0]       nz_cnt;
  logic                           pat_last;
  logic [PB-1:0]                  tail;
  logic [slpg_pkg::IdxW-1:0]      piv;
  logic                           found;
  logic [PB-1:0]                  nxt_parts [MD];
  logic [127:0]                   coords;
  logic                           is_last;
  logic                           accept;
  logic                           root_done;
  logic [slpg_pkg::MagW-1:0]      root_mag;
  logic                           out_free;

  slpg_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slpg_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == ST_START),
    .part_i  (parts_q[idx_q]),
    .den_i   (den_e),
    .done_o  (root_done),
    .mag_o   (root_mag)
  );

  assign den_e    = slpg_pkg::eff_den(cfg.den);
  assign dim_e    = slpg_pkg::eff_dim(cfg.dim);
  assign last_idx = slpg_pkg::IdxW'(dim_e - slpg_pkg::DimW'(1));
  assign tail     = parts_q[last_idx];

  // nonzero parts in use, and whether the sign pattern is the final one
  always_comb begin
    pat_last = 1'b1;
    for (int j = 0; j < MD; j++) begin
      nz[j] = (slpg_pkg::DimW'(j) < dim_e) && (parts_q[j] != '0);
    end
    nz_cnt = slpg_pkg::NzW'($countones(nz));
    for (int b = 0; b < MD; b++) begin
      if (sign_q[b] != (slpg_pkg::NzW'(b) < nz_cnt)) pat_last = 1'b0;
    end
  end

  // pivot: highest nonzero part below the tail
  always_comb begin
    piv   = '0;
    found = 1'b0;
    for (int j = 0; j < MD; j++) begin
      if ((slpg_pkg::IdxW'(j) < last_idx) && (parts_q[j] != '0)) begin
        piv   = slpg_pkg::IdxW'(j);
        found = 1'b1;
      end
    end
  end

  // next composition: move one unit right of the pivot and fold the tail in
  always_comb begin
    for (int j = 0; j < MD; j++) begin
      if (found && (slpg_pkg::IdxW'(j) == piv + slpg_pkg::IdxW'(1)) && (j != 0)) begin
        nxt_parts[j] = ((slpg_pkg::IdxW'(j) == last_idx) ? '0 : parts_q[j])
                       + PB'(1) + tail;
      end else if (slpg_pkg::IdxW'(j) == last_idx) begin
        nxt_parts[j] = '0;
      end else if (found && (slpg_pkg::IdxW'(j) == piv)) begin
        nxt_parts[j] = parts_q[j] - PB'(1);
      end else begin
        nxt_parts[j] = parts_q[j];
      end
    end
  end

  // output word: k-th nonzero part takes sign bit k
  always_comb begin
    logic [slpg_pkg::NzW-1:0]    k;
    logic [slpg_pkg::CoordW-1:0] v;
    k      = '0;
    coords = '0;
    for (int j = 0; j < MD; j++) begin
      v = '0;
      if (nz[j]) begin
        v = {1'b0, mag_q[j]};
        if (sign_q[k[slpg_pkg::IdxW-1:0]]) v = -v;
        k = k + slpg_pkg::NzW'(1);
      end
      coords[j*slpg_pkg::CoordW +: slpg_pkg::CoordW] = v;
    end
  end

  assign is_last         = (tail == den_e) && pat_last;
  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !mv_q || m_axis_tready_i;

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tlast_o  = mlast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      first_q <= 1'b1;
      sign_q  <= '0;
      idx_q   <= '0;
      mv_q    <= 1'b0;
      for (int j = 0; j < MD; j++) begin
        parts_q[j] <= (j == 0) ? PB'(4) : '0;
      end
    end else begin
      // output register: loads from emit, empties when taken
      if ((st_q == ST_EMIT) && out_free) mv_q <= 1'b1;
      else if (m_axis_tready_i) mv_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tdata_i[0] || first_q ||
                (pat_last && ((tail == den_e) || !found))) begin
              // back to the first composition
              for (int j = 0; j < MD; j++) begin
                parts_q[j] <= (j == 0) ? den_e : '0;
              end
              sign_q     <= '0;
              idx_q      <= '0;
              st_q       <= ST_START;
            end else if (pat_last) begin
              for (int j = 0; j < MD; j++) begin
                parts_q[j] <= nxt_parts[j];
              end
              sign_q <= '0;
              idx_q  <= '0;
              st_q   <= ST_START;
            end else begin
              sign_q <= sign_q + MD'(1);
              st_q   <= ST_EMIT;
            end
          end
        end
        ST_START: st_q <= ST_WAIT;
        ST_WAIT: begin
          if (root_done) begin
            mag_q[idx_q] <= root_mag;
            if (idx_q == last_idx) begin
              st_q <= ST_EMIT;
            end else begin
              idx_q <= idx_q + slpg_pkg::IdxW'(1);
              st_q  <= ST_START;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            mdata_q <= coords;
            mlast_q <= is_last;
            st_q    <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
      // any register write restarts the walk on the next word
      if (cfg.wr) first_q <= 1'b1;
      else if (accept) first_q <= 1'b0;
    end
  end

endmodule

// ----- sv/slpg_checker.sv -----
// port-level assertions for the sphere lattice point generator, bound to the top level
// depends on sphere_lattice_point_generator_unit
module slpg_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [127:0] m_axis_tdata_o,
  input logic         m_axis_tlast_o
);

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // first coordinate stays on the unit range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(m_axis_tdata_o[15:0]) >= -16'sd16384) &&
      ($signed(m_axis_tdata_o[15:0]) <= 16'sd16384))
    else $error("coordinate 0 out of range");

  // final point has zero weight in the first coordinate
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[15:0] == 16'h0000)
    else $error("final point with nonzero first coordinate");

endmodule

bind sphere_lattice_point_generator_unit slpg_checker u_slpg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
